// ===== design/nscs_pkg.sv =====
// nscs_pkg: shared types and constants of the start code scanner
// result record, event codes, register map and tail length
// no dependencies
package nscs_pkg;

   localparam int unsigned COUNT_W       = 20;
   localparam int unsigned WORD_W        = 32;
   localparam int unsigned RSP_DEPTH_DEF = 4;

   localparam logic [WORD_W-1:0]  TAIL_BYTES = 32'd32;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};

   localparam logic [7:0] BYTE_ZERO  = 8'h00;
   localparam logic [7:0] BYTE_ONE   = 8'h01;
   localparam logic [7:0] NAL_IDR    = 8'h65;
   localparam logic [7:0] NAL_SPS    = 8'h67;
   localparam logic [7:0] NAL_PPS    = 8'h68;

   localparam logic [1:0] ZERO_RUN_MIN   = 2'd2;
   localparam logic [1:0] ZERO_RUN_RESET = 2'd3;
   localparam logic [1:0] ZERO_RUN_SAT   = 2'd3;

   // register index, taken from paddr[2]
   typedef enum logic {
      REG_STREAM_LENGTH = 1'b0,
      REG_MIN_ZERO_RUN  = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      EV_SAMPLE   = 2'd0,
      EV_END_SIZE = 2'd1,
      EV_END_NONE = 2'd2
   } event_type;

   typedef enum logic {
      KIND_IDR   = 1'b0,
      KIND_PARAM = 1'b1
   } kind_type;

   typedef struct packed {
      event_type          event_res;
      logic [COUNT_W-1:0] sample_index;
      logic [WORD_W-1:0]  header_offset;
      kind_type           sample_kind;
      logic [WORD_W-1:0]  size_bytes;
      logic               size_valid;
      logic [COUNT_W-1:0] idr_count;
      logic               last_of_run;
   } result_type;

endpackage

// ===== design/nal_start_code_scanner.sv =====
// nal_start_code_scanner: annex b start code scanner with sample reporting
// one byte register, single pass classify logic, small result queue
// depends on nscs_pkg
//
// a byte is held in the byte register and its results are then written to the result queue
// throughput: one byte per cycle while req_stall is low; the end-of-scan byte may queue two results
// the result queue (RSP_DEPTH entries) decouples the sides; input stalls only
// when the byte register holds an item and the queue lacks room for two
// reset (synchronous, active high) clears all scan state, the queue and the
// registers (stream_length to 0, min_zero_run to 3)
module nal_start_code_scanner
   import nscs_pkg::*;
#(
   parameter int unsigned RSP_DEPTH = RSP_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // byte input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_stream_byte,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_event_res,
   output logic [COUNT_W-1:0] rsp_sample_index,
   output logic [WORD_W-1:0]  rsp_header_offset,
   output logic               rsp_sample_kind,
   output logic [WORD_W-1:0]  rsp_size_bytes,
   output logic               rsp_size_valid,
   output logic [COUNT_W-1:0] rsp_idr_count,
   output logic               rsp_last_of_run,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [WORD_W-1:0]  pwdata,
   output logic [WORD_W-1:0]  prdata,
   output logic               pready
);

   localparam int unsigned PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(RSP_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RSP_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_ROOM2 = CNT_W'(RSP_DEPTH - 2);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
   endfunction

   // ---------------- register port ----------------
   logic [WORD_W-1:0] stream_length_ff;
   logic [1:0]        min_zero_run_ff;
   reg_index_type     reg_sel;
   logic              reg_write;

   assign pready    = 1'b1;
   assign reg_sel   = reg_index_type'(paddr[2]);
   assign reg_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_length_ff <= '0;
         min_zero_run_ff  <= ZERO_RUN_RESET;
      end else if (reg_write) begin
         unique case (reg_sel)
            REG_STREAM_LENGTH: stream_length_ff <= pwdata;
            REG_MIN_ZERO_RUN:  min_zero_run_ff  <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_STREAM_LENGTH: prdata = stream_length_ff;
         REG_MIN_ZERO_RUN:  prdata = {{(WORD_W-2){1'b0}}, min_zero_run_ff};
         default:           prdata = '0;
      endcase
   end

   // ---------------- byte register ----------------
   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              room2;
   logic              process;
   logic              req_take;

   // the byte is worked on only when the queue can take two results
   assign room2    = (count_ff <= CNT_ROOM2);
   assign process  = in_valid_ff & room2;
   assign req_stall = in_valid_ff & ~room2;
   assign req_take = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (process) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_stream_byte;
      end
   end

   // ---------------- scan state ----------------
   logic [1:0]         zero_run_ff,    zero_run_in;
   logic               hdr_pending_ff, hdr_pending_in;
   logic [WORD_W-1:0]  byte_pos_ff,    byte_pos_in;
   logic [WORD_W-1:0]  prev_off_ff,    prev_off_in;
   logic [COUNT_W-1:0] found_ff,       found_in;
   logic [COUNT_W-1:0] sync_ff,        sync_in;
   logic               scan_done_ff,   scan_done_in;

   logic [WORD_W-1:0]  scan_limit;
   logic [1:0]         zero_need;
   logic               is_hit;
   logic               is_idr;
   logic               consume;
   logic               at_end;
   result_type         res_hit;
   result_type         res_end;
   result_type         push_a;
   result_type         push_b;
   logic [1:0]         push_n;

   always_comb begin
      // bytes below stream_length - 32 are scanned
      scan_limit = (stream_length_ff >= TAIL_BYTES) ? stream_length_ff - TAIL_BYTES : '0;
      zero_need  = (min_zero_run_ff < ZERO_RUN_MIN) ? ZERO_RUN_MIN : min_zero_run_ff;

      // header byte after a start code
      is_idr = (in_byte_ff == NAL_IDR);
      is_hit = hdr_pending_ff &
               (is_idr || in_byte_ff == NAL_SPS || in_byte_ff == NAL_PPS);

      sync_in     = (is_hit & is_idr) ? sat_inc(sync_ff) : sync_ff;
      found_in    = is_hit ? sat_inc(found_ff) : found_ff;
      prev_off_in = is_hit ? byte_pos_ff : prev_off_ff;

      res_hit.event_res     = EV_SAMPLE;
      res_hit.sample_index  = found_ff;
      res_hit.header_offset = byte_pos_ff;
      res_hit.sample_kind   = is_idr ? KIND_IDR : KIND_PARAM;
      res_hit.size_bytes    = (found_ff != '0) ? byte_pos_ff - prev_off_ff : '0;
      res_hit.size_valid    = (found_ff != '0);
      res_hit.idr_count     = sync_in;
      res_hit.last_of_run   = 1'b0;

      // header byte within the limit also counts for zero runs
      consume        = (byte_pos_ff < scan_limit);
      byte_pos_in    = consume ? byte_pos_ff + WORD_W'(1) : byte_pos_ff;
      zero_run_in    = zero_run_ff;
      hdr_pending_in = 1'b0;
      if (consume) begin
         if (in_byte_ff == BYTE_ZERO) begin
            zero_run_in = (zero_run_ff == ZERO_RUN_SAT) ? zero_run_ff
                                                        : zero_run_ff + 2'd1;
         end else begin
            hdr_pending_in = (in_byte_ff == BYTE_ONE) && (zero_run_ff >= zero_need);
            zero_run_in    = '0;
         end
      end

      at_end       = (byte_pos_in >= scan_limit) & ~hdr_pending_in;
      scan_done_in = at_end;

      if (found_in == '0) begin
         res_end.event_res     = EV_END_NONE;
         res_end.sample_index  = '0;
         res_end.header_offset = '0;
         res_end.size_bytes    = '0;
         res_end.size_valid    = 1'b0;
      end else begin
         res_end.event_res     = EV_END_SIZE;
         res_end.sample_index  = found_in;
         res_end.header_offset = prev_off_in;
         res_end.size_bytes    = stream_length_ff - prev_off_in;
         res_end.size_valid    = 1'b1;
      end
      res_end.sample_kind = KIND_IDR;
      res_end.idr_count   = sync_in;
      res_end.last_of_run = 1'b1;

      // order in the queue: sample hit first, then the end report
      push_a = is_hit ? res_hit : res_end;
      push_b = res_end;
      if (!process || scan_done_ff) begin
         push_n = 2'd0;
      end else begin
         push_n = {1'b0, is_hit} + {1'b0, at_end};
      end
      if (push_n == 2'd1) begin
         push_a.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_run_ff    <= '0;
         hdr_pending_ff <= 1'b0;
         byte_pos_ff    <= '0;
         prev_off_ff    <= '0;
         found_ff       <= '0;
         sync_ff        <= '0;
         scan_done_ff   <= 1'b0;
      end else if (process && !scan_done_ff) begin
         zero_run_ff    <= zero_run_in;
         hdr_pending_ff <= hdr_pending_in;
         byte_pos_ff    <= byte_pos_in;
         prev_off_ff    <= prev_off_in;
         found_ff       <= found_in;
         sync_ff        <= sync_in;
         scan_done_ff   <= scan_done_in;
      end
   end

   // ---------------- result queue ----------------
   result_type       rsp_mem [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_in;
   logic             pop;
   result_type       rsp_head;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid & ~rsp_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_n == 2'd1) begin
         wr_ptr_in = ptr_next(wr_ptr_ff);
      end else if (push_n == 2'd2) begin
         wr_ptr_in = ptr_next(ptr_next(wr_ptr_ff));
      end
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         rsp_mem[wr_ptr_ff] <= push_a;
      end
      if (push_n == 2'd2) begin
         rsp_mem[ptr_next(wr_ptr_ff)] <= push_b;
      end
   end

   assign rsp_head          = rsp_mem[rd_ptr_ff];
   assign rsp_event_res     = rsp_head.event_res;
   assign rsp_sample_index  = rsp_head.sample_index;
   assign rsp_header_offset = rsp_head.header_offset;
   assign rsp_sample_kind   = rsp_head.sample_kind;
   assign rsp_size_bytes    = rsp_head.size_bytes;
   assign rsp_size_valid    = rsp_head.size_valid;
   assign rsp_idr_count     = rsp_head.idr_count;
   assign rsp_last_of_run   = rsp_head.last_of_run;

`ifndef SYNTHESIS
   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   // nothing is queued once the scan has ended
   a_quiet_after_end: assert property (@(posedge clock) disable iff (reset)
      scan_done_ff |-> push_n == 2'd0)
      else $error("result after scan end");

   // sample counter never goes backwards
   a_found_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> found_ff >= $past(found_ff))
      else $error("found count decreased");

   // the end report is always the last of its byte and sets the done flag
   a_end_sets_done: assert property (@(posedge clock) disable iff (reset)
      push_n != 2'd0 && at_end |=> scan_done_ff)
      else $error("end report without scan done");
`endif

endmodule
